// ----- src/pal_pkg.sv -----
// Package for the positional array list: command codes, widths, cell control word.
package pal_pkg;

    localparam int PAL_CAPACITY = 64;
    localparam int PAL_DW       = 32;
    localparam int PAL_GRP      = 8;
    localparam int PAL_GRP_W    = 3;
    localparam int PAL_PORT_W   = 7;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_LOCATE = 3'd3,
        OP_READ   = 3'd4
    } pal_op_t;

    // Broadcast to every cell in the cycle a command word is taken.
    typedef struct packed {
        logic go;
        logic go_ins;
        logic go_del;
        logic sel_en;
        logic match_en;
    } pal_ctrl_t;

endpackage

// ----- src/pal_cell.sv -----
// One list cell: holds one entry, shifts with its neighbors, flags a position or value hit.
module pal_cell #(
    parameter int CAPACITY = pal_pkg::PAL_CAPACITY,
    parameter int IDX      = 0
) (
    input  logic                                    clk,
    input  pal_pkg::pal_ctrl_t                      ctrl,
    input  logic [$clog2(CAPACITY)-1:0]             pidx,
    input  logic [pal_pkg::PAL_DW-1:0]              val,
    input  logic [$clog2(CAPACITY+1)-1:0]           count,
    input  logic [pal_pkg::PAL_DW-1:0]              left_entry,
    input  logic [pal_pkg::PAL_DW-1:0]              right_entry,
    output logic [pal_pkg::PAL_DW-1:0]              entry,
    output logic                                    hit,
    output logic [pal_pkg::PAL_DW-1:0]              hit_data
);
    import pal_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);
    localparam logic [CW-1:0] MY_CNT = CW'(IDX);

    logic [PAL_DW-1:0] entry_reg, entry_next;
    logic              hit_reg, hit_next;
    logic [PAL_DW-1:0] hit_data_reg, hit_data_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.go_ins)
        begin
            if (MY_IDX == pidx)
                entry_next = val;
            else if (MY_IDX > pidx)
                entry_next = left_entry;
        end
        else if (ctrl.go_del)
        begin
            if (MY_IDX >= pidx)
                entry_next = right_entry;
        end
    end

    always_comb
    begin
        hit_next = (ctrl.sel_en && (MY_IDX == pidx))
                || (ctrl.match_en && (entry_reg == val) && (MY_CNT < count));
        // data is taken before the shift so delete returns the old entry
        hit_data_next = hit_next ? entry_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (ctrl.go)
        begin
            hit_reg      <= hit_next;
            hit_data_reg <= hit_data_next;
        end
    end

    assign entry    = entry_reg;
    assign hit      = hit_reg;
    assign hit_data = hit_data_reg;

endmodule

// ----- src/pal_group.sv -----
// Registered reduction of one group of cell hits: any hit, first hit index, OR of hit data.
module pal_group (
    input  logic                                            clk,
    input  logic [pal_pkg::PAL_GRP-1:0]                     hits,
    input  logic [pal_pkg::PAL_GRP*pal_pkg::PAL_DW-1:0]     data,
    output logic                                            any,
    output logic [pal_pkg::PAL_GRP_W-1:0]                   first,
    output logic [pal_pkg::PAL_DW-1:0]                      data_or
);
    import pal_pkg::*;

    logic                 any_next;
    logic [PAL_GRP_W-1:0] first_next;
    logic [PAL_DW-1:0]    data_or_next;
    logic                 any_reg;
    logic [PAL_GRP_W-1:0] first_reg;
    logic [PAL_DW-1:0]    data_or_reg;

    always_comb
    begin
        any_next     = |hits;
        first_next   = '0;
        data_or_next = '0;
        for (int k = PAL_GRP - 1; k >= 0; k--)
        begin
            if (hits[k])
                first_next = PAL_GRP_W'(k);
            data_or_next = data_or_next | data[k*PAL_DW +: PAL_DW];
        end
    end

    always_ff @(posedge clk)
    begin
        any_reg     <= any_next;
        first_reg   <= first_next;
        data_or_reg <= data_or_next;
    end

    assign any     = any_reg;
    assign first   = first_reg;
    assign data_or = data_or_reg;

endmodule

// ----- src/positional_array_list.sv -----
// Top level of the positional array list: cell row, hit reduction, result register.
//
// A command word is taken when start is high and busy is low; its result appears on the
// result ports with done high for exactly one cycle, and the receiver cannot stall it.
// The list is a row of CAPACITY cells, one entry each, so insert and delete shift all
// later entries in the cycle the word is taken. The hit flags of the cells are then
// folded by a registered two-level tree (groups of eight, then across groups) through
// the cell hit, group and result registers; busy stays high while a word is in the cell
// and group registers, so a new word is not taken before the last one reaches the result.
module positional_array_list #(
    parameter int CAPACITY = pal_pkg::PAL_CAPACITY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [2:0]                        cmd,
    input  logic [pal_pkg::PAL_PORT_W-1:0]    position,
    input  logic signed [pal_pkg::PAL_DW-1:0] value,
    output logic                              done,
    output logic                              ok,
    output logic signed [pal_pkg::PAL_DW-1:0] data_out,
    output logic [pal_pkg::PAL_PORT_W-1:0]    found_position,
    output logic [pal_pkg::PAL_PORT_W-1:0]    list_length,
    output logic                              is_empty
);
    import pal_pkg::*;

    localparam int IW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int LW  = (CW > PAL_PORT_W ? CW : PAL_PORT_W) + 1;
    localparam int NG  = (CAPACITY + PAL_GRP - 1) / PAL_GRP;
    localparam int NP  = NG * PAL_GRP;
    localparam int FW  = $clog2(NP) + 1;

    // control
    logic          acc;
    logic [LW-1:0] pos_w, cnt_w;
    logic          ins_ok, rd_ok;
    pal_ctrl_t     ctrl;
    logic [IW-1:0] pidx;

    logic [CW-1:0] count_reg, count_next;
    logic          s1_vld_reg, s2_vld_reg, done_reg;
    logic [2:0]    op1_reg, op2_reg;
    logic          ok1_reg, ok1_next, ok2_reg;

    // cell row
    logic [PAL_DW-1:0] ent [CAPACITY];
    logic [NP-1:0]          hit_pad;
    logic [NP*PAL_DW-1:0]   data_pad;

    // group results
    logic [NG-1:0]        g_any;
    logic [PAL_GRP_W-1:0] g_first [NG];
    logic [PAL_DW-1:0]    g_data  [NG];

    // final fold and result registers
    logic              any_hit;
    logic [FW-1:0]     fpos;
    logic [PAL_DW-1:0] data_all;
    logic              ok_reg, ok_next;
    logic [PAL_DW-1:0] data_reg, data_next;
    logic [PAL_PORT_W-1:0] found_reg, found_next;
    logic [PAL_PORT_W-1:0] len_reg;
    logic              empty_reg;

    assign busy = s1_vld_reg | s2_vld_reg;
    assign acc  = start & ~busy;

    always_comb
    begin
        pos_w  = LW'(position);
        cnt_w  = LW'(count_reg);
        ins_ok = (pos_w != '0) && (pos_w <= cnt_w + LW'(1)) && (cnt_w < LW'(CAPACITY));
        rd_ok  = (pos_w != '0) && (pos_w <= cnt_w);
        pidx   = IW'(pos_w - LW'(1));

        ctrl.go       = acc;
        ctrl.go_ins   = acc && (cmd == OP_INSERT) && ins_ok;
        ctrl.go_del   = acc && (cmd == OP_DELETE) && rd_ok;
        ctrl.sel_en   = acc && (cmd inside {OP_DELETE, OP_READ}) && rd_ok;
        ctrl.match_en = acc && (cmd == OP_LOCATE);
    end

    always_comb
    begin
        count_next = count_reg;
        ok1_next   = 1'b0;
        case (cmd)
            OP_CLEAR:
            begin
                count_next = '0;
                ok1_next   = 1'b1;
            end
            OP_INSERT:
            begin
                ok1_next = ins_ok;
                if (ins_ok)
                    count_next = count_reg + CW'(1);
            end
            OP_DELETE:
            begin
                ok1_next = rd_ok;
                if (rd_ok)
                    count_next = count_reg - CW'(1);
            end
            OP_READ:
                ok1_next = rd_ok;
            default:
                ok1_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (acc)
                count_reg <= count_next;
            s1_vld_reg <= acc;
            s2_vld_reg <= s1_vld_reg;
            done_reg   <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            op1_reg <= cmd;
            ok1_reg <= ok1_next;
        end
        if (s1_vld_reg)
        begin
            op2_reg <= op1_reg;
            ok2_reg <= ok1_reg;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [PAL_DW-1:0] left_w, right_w;
            logic              hit_w;
            logic [PAL_DW-1:0] hdata_w;

            if (gi == 0)
            begin : g_first_cell
                assign left_w = '0;
            end
            else
            begin : g_mid_left
                assign left_w = ent[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last_cell
                assign right_w = '0;
            end
            else
            begin : g_mid_right
                assign right_w = ent[gi+1];
            end

            pal_cell #(
                .CAPACITY (CAPACITY),
                .IDX      (gi)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .pidx        (pidx),
                .val         (value),
                .count       (count_reg),
                .left_entry  (left_w),
                .right_entry (right_w),
                .entry       (ent[gi]),
                .hit         (hit_w),
                .hit_data    (hdata_w)
            );

            assign hit_pad[gi]                 = hit_w;
            assign data_pad[gi*PAL_DW +: PAL_DW] = hdata_w;
        end

        for (gi = CAPACITY; gi < NP; gi++)
        begin : g_pad
            assign hit_pad[gi]                 = 1'b0;
            assign data_pad[gi*PAL_DW +: PAL_DW] = '0;
        end

        for (gi = 0; gi < NG; gi++)
        begin : g_grp
            pal_group u_grp (
                .clk     (clk),
                .hits    (hit_pad[gi*PAL_GRP +: PAL_GRP]),
                .data    (data_pad[gi*PAL_GRP*PAL_DW +: PAL_GRP*PAL_DW]),
                .any     (g_any[gi]),
                .first   (g_first[gi]),
                .data_or (g_data[gi])
            );
        end
    endgenerate

    // lowest group with a hit wins; fpos is 1-based
    always_comb
    begin
        any_hit  = |g_any;
        fpos     = '0;
        data_all = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (g_any[g])
                fpos = FW'(g * PAL_GRP) + FW'(g_first[g]) + FW'(1);
            data_all = data_all | g_data[g];
        end
    end

    always_comb
    begin
        ok_next    = ok2_reg;
        data_next  = '0;
        found_next = '0;
        case (op2_reg)
            OP_LOCATE:
            begin
                ok_next = any_hit;
                if (any_hit)
                    found_next = PAL_PORT_W'(fpos);
            end
            OP_DELETE, OP_READ:
                data_next = data_all;
            default:
                data_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s2_vld_reg)
        begin
            ok_reg    <= ok_next;
            data_reg  <= data_next;
            found_reg <= found_next;
            len_reg   <= PAL_PORT_W'(count_reg);
            empty_reg <= (count_reg == '0);
        end
    end

    assign done           = done_reg;
    assign ok             = ok_reg;
    assign data_out       = data_reg;
    assign found_position = found_reg;
    assign list_length    = len_reg;
    assign is_empty       = empty_reg;

endmodule

// ----- src/pal_checker.sv -----
// Port-level checks for the positional array list, bound to the top level.
module pal_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input logic                           ok,
    input logic [pal_pkg::PAL_PORT_W-1:0] found_position,
    input logic [pal_pkg::PAL_PORT_W-1:0] list_length,
    input logic                           is_empty
);
    import pal_pkg::*;

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a word was taken");

    a_no_done_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result strobed one cycle after a take");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while busy");

    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_empty == (list_length == '0)))
        else $error("is_empty disagrees with list_length");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (found_position != '0)) |-> ok)
        else $error("found position reported without ok");

endmodule

bind positional_array_list pal_checker u_pal_checker (.*);
